/* sv/great_circle_zone_proximity_check_core_macros.svh */
// Assertion macros used by the top module of the zone proximity core.
`ifndef GREAT_CIRCLE_ZONE_PROXIMITY_CHECK_CORE_MACROS_SVH
`define GREAT_CIRCLE_ZONE_PROXIMITY_CHECK_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GCZP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define GCZP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/gczp_pkg.sv */
package gczp_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int LAT_SC       = CORDIC_STEPS + 4;
    localparam int LAT_XYZ      = LAT_SC + 2;

    localparam int LAT_W  = 24;
    localparam int ANG_W  = 25;
    localparam int ALT_W  = 17;
    localparam int RAD_W  = 20;
    localparam int TRIG_W = 32;
    localparam int CRD_W  = 30;
    localparam int SQ_W   = 62;
    localparam int ROOT_W = 31;
    localparam int DEN_W  = ROOT_W + 8;
    localparam int QUO_W  = 24;
    localparam int DIST_W = 22;

    localparam logic signed [ANG_W:0] DEG_90  = 26'sd5898240;
    localparam logic signed [ANG_W:0] DEG_180 = 26'sd11796480;
    localparam logic signed [ANG_W:0] DEG_360 = 26'sd23592960;

    localparam longint DEG_TO_RAD = 64'sd19190098068;
    localparam logic signed [17:0] DEG_RAD_HI = 18'(DEG_TO_RAD >> 18);
    localparam logic signed [17:0] DEG_RAD_LO = 18'(DEG_TO_RAD & 64'sd262143);

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [CRD_W-1:0]  EARTH_R     = 30'sd417529856;
    localparam logic signed [21:0]       FT_TO_KM    = 22'sd1309106;

    localparam logic [60:0]      LIM_30       = 61'd1073741824;
    localparam logic [QUO_W-1:0] DIST_POS_MAX = 24'd2097151;
    localparam logic [QUO_W-1:0] DIST_NEG_MAX = 24'd2097152;
    localparam logic signed [DIST_W-1:0] DIST_MAX = 22'sd2097151;
    localparam logic signed [DIST_W-1:0] DIST_MIN = -22'sd2097152;

    localparam logic signed [TRIG_W-1:0] ATAN_Q30 [32] = '{
        32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6,
        32'sh03FEAB76, 32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55,
        32'sh003FFFEA, 32'sh001FFFFD, 32'sh000FFFFF, 32'sh0007FFFF,
        32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF, 32'sh00007FFF,
        32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
        32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F,
        32'sh0000003F, 32'sh0000001F, 32'sh0000000F, 32'sh00000008,
        32'sh00000004, 32'sh00000002, 32'sh00000001, 32'sh00000000
    };

    typedef enum logic [7:0] {
        CFG_ZONE_LAT    = 8'd0,
        CFG_ZONE_LON    = 8'd1,
        CFG_ZONE_ALT    = 8'd2,
        CFG_ZONE_RADIUS = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        logic neg;
        logic deg;
    } t_res_tag;

    typedef struct packed {
        logic [SQ_W-1:0] dot_mag;
        t_res_tag        res;
    } t_sq_tag;

endpackage

/* sv/gczp_sincos.sv */
module gczp_sincos import gczp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [ANG_W-1:0]  i_angle,
    output logic signed [TRIG_W-1:0] o_sin,
    output logic signed [TRIG_W-1:0] o_cos
);

    logic signed [ANG_W:0]   w_wrap;
    logic signed [ANG_W:0]   w_fold;
    logic                    w_neg;
    logic signed [LAT_W-1:0] r_a;
    logic                    r_neg1;
    logic signed [41:0]      r_ph;
    logic signed [41:0]      r_pl;
    logic                    r_neg2;
    logic signed [59:0]      w_zs;

    logic signed [TRIG_W-1:0] r_cx [0:CORDIC_STEPS];
    logic signed [TRIG_W-1:0] r_cy [0:CORDIC_STEPS];
    logic signed [TRIG_W-1:0] r_cz [0:CORDIC_STEPS];
    logic                     r_cn [0:CORDIC_STEPS];

    always_comb begin
        w_wrap = (ANG_W+1)'(i_angle);
        if (w_wrap >= DEG_180) begin
            w_wrap = w_wrap - DEG_360;
        end else if (w_wrap < -DEG_180) begin
            w_wrap = w_wrap + DEG_360;
        end
        w_fold = w_wrap;
        w_neg  = 1'b0;
        if (w_wrap > DEG_90) begin
            w_fold = w_wrap - DEG_180;
            w_neg  = 1'b1;
        end else if (w_wrap < -DEG_90) begin
            w_fold = w_wrap + DEG_180;
            w_neg  = 1'b1;
        end
    end

    assign w_zs = (60'(r_ph) <<< 18) + 60'(r_pl);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a       <= w_fold[LAT_W-1:0];
            r_neg1    <= w_neg;
            r_ph      <= r_a * DEG_RAD_HI;
            r_pl      <= r_a * DEG_RAD_LO;
            r_neg2    <= r_neg1;
            r_cx[0]   <= CORDIC_GAIN;
            r_cy[0]   <= '0;
            r_cz[0]   <= w_zs[26+TRIG_W-1:26];
            r_cn[0]   <= r_neg2;
            o_sin     <= r_cn[CORDIC_STEPS] ? -r_cy[CORDIC_STEPS] : r_cy[CORDIC_STEPS];
            o_cos     <= r_cn[CORDIC_STEPS] ? -r_cx[CORDIC_STEPS] : r_cx[CORDIC_STEPS];
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        logic signed [TRIG_W-1:0] w_dx;
        logic signed [TRIG_W-1:0] w_dy;
        assign w_dx = r_cy[g] >>> g;
        assign w_dy = r_cx[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cn[g+1] <= r_cn[g];
                if (!r_cz[g][TRIG_W-1]) begin
                    r_cx[g+1] <= r_cx[g] - w_dx;
                    r_cy[g+1] <= r_cy[g] + w_dy;
                    r_cz[g+1] <= r_cz[g] - ATAN_Q30[g];
                end else begin
                    r_cx[g+1] <= r_cx[g] + w_dx;
                    r_cy[g+1] <= r_cy[g] - w_dy;
                    r_cz[g+1] <= r_cz[g] + ATAN_Q30[g];
                end
            end
        end
    end

endmodule

/* sv/gczp_xyz.sv */
module gczp_xyz import gczp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [LAT_W-1:0] i_lat,
    input  logic signed [ANG_W-1:0] i_lon,
    input  logic signed [ALT_W-1:0] i_alt,
    output logic                    o_valid,
    output logic signed [CRD_W-1:0] o_x,
    output logic signed [CRD_W-1:0] o_y,
    output logic signed [CRD_W-1:0] o_z
);

    logic signed [TRIG_W-1:0] w_sl;
    logic signed [TRIG_W-1:0] w_cl;
    logic signed [TRIG_W-1:0] w_so;
    logic signed [TRIG_W-1:0] w_co;
    logic signed [38:0]       w_alt_km;
    logic signed [CRD_W-1:0]  w_r;
    logic signed [CRD_W-1:0]  r_r [0:LAT_SC-1];
    logic                     r_vd [0:LAT_XYZ-1];
    logic signed [61:0]       w_rc;
    logic signed [61:0]       w_pz;
    logic signed [CRD_W-1:0]  r_rc;
    logic signed [CRD_W-1:0]  r_pz;
    logic signed [TRIG_W-1:0] r_so;
    logic signed [TRIG_W-1:0] r_co;
    logic signed [61:0]       w_px;
    logic signed [61:0]       w_py;

    gczp_sincos u_lat (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_angle (ANG_W'(i_lat)),
        .o_sin   (w_sl),
        .o_cos   (w_cl)
    );

    gczp_sincos u_lon (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_angle (i_lon),
        .o_sin   (w_so),
        .o_cos   (w_co)
    );

    assign w_alt_km = i_alt * FT_TO_KM;
    assign w_r      = EARTH_R + CRD_W'(w_alt_km >>> 16);
    assign w_rc     = r_r[LAT_SC-1] * w_cl;
    assign w_pz     = r_r[LAT_SC-1] * w_sl;
    assign w_px     = r_rc * r_co;
    assign w_py     = r_rc * r_so;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT_XYZ; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vd[0] <= i_valid;
            for (int k = 1; k < LAT_XYZ; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0] <= w_r;
            for (int k = 1; k < LAT_SC; k++) begin
                r_r[k] <= r_r[k-1];
            end
            r_rc <= w_rc[30+CRD_W-1:30];
            r_pz <= w_pz[30+CRD_W-1:30];
            r_so <= w_so;
            r_co <= w_co;
            o_x  <= w_px[30+CRD_W-1:30];
            o_y  <= w_py[30+CRD_W-1:30];
            o_z  <= r_pz;
        end
    end

    assign o_valid = r_vd[LAT_XYZ-1];

endmodule

/* sv/gczp_isqrt.sv */
module gczp_isqrt import gczp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_sq,
    input  t_sq_tag           i_tag,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_sq_tag           o_tag
);

    logic [SQ_W-1:0]   r_val  [0:ROOT_W];
    logic [ROOT_W-1:0] r_root [0:ROOT_W];
    logic [SQ_W:0]     r_rsq  [0:ROOT_W];
    t_sq_tag           r_tag  [0:ROOT_W];
    logic              r_vd   [0:ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ROOT_W; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vd[0] <= i_valid;
            for (int k = 1; k <= ROOT_W; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val[0]  <= i_sq;
            r_root[0] <= '0;
            r_rsq[0]  <= '0;
            r_tag[0]  <= i_tag;
        end
    end

    for (genvar g = 0; g < ROOT_W; g++) begin : g_bit
        localparam int SH = ROOT_W - 1 - g;
        logic [SQ_W:0] w_trial;
        assign w_trial = r_rsq[g] + ((SQ_W+1)'(r_root[g]) << (SH + 1))
                       + ((SQ_W+1)'(1) << (2 * SH));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val[g+1] <= r_val[g];
                r_tag[g+1] <= r_tag[g];
                if ({1'b0, r_val[g]} >= w_trial) begin
                    r_root[g+1] <= r_root[g] | (ROOT_W'(1) << SH);
                    r_rsq[g+1]  <= w_trial;
                end else begin
                    r_root[g+1] <= r_root[g];
                    r_rsq[g+1]  <= r_rsq[g];
                end
            end
        end
    end

    assign o_valid = r_vd[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_tag   = r_tag[ROOT_W];

endmodule

/* sv/gczp_div.sv */
module gczp_div import gczp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [ROOT_W-1:0] i_root,
    input  logic [SQ_W-1:0]   i_dot_mag,
    input  t_res_tag          i_tag,
    output logic              o_valid,
    output logic [QUO_W-1:0]  o_quo,
    output t_res_tag          o_tag
);

    logic [SQ_W-1:0]  r_rem [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic [QUO_W-1:0] r_quo [0:QUO_W];
    t_res_tag         r_tag [0:QUO_W];
    logic             r_vd  [0:QUO_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QUO_W; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vd[0] <= i_valid;
            for (int k = 1; k <= QUO_W; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_dot_mag;
            r_den[0] <= {i_root, 8'd0};
            r_quo[0] <= '0;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar g = 0; g < QUO_W; g++) begin : g_bit
        localparam int SH = QUO_W - 1 - g;
        logic [63:0] w_ds;
        assign w_ds = 64'(r_den[g]) << SH;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[g+1] <= r_den[g];
                r_tag[g+1] <= r_tag[g];
                if (64'(r_rem[g]) >= w_ds) begin
                    r_rem[g+1] <= r_rem[g] - w_ds[SQ_W-1:0];
                    r_quo[g+1] <= r_quo[g] | (QUO_W'(1) << SH);
                end else begin
                    r_rem[g+1] <= r_rem[g];
                    r_quo[g+1] <= r_quo[g];
                end
            end
        end
    end

    assign o_valid = r_vd[QUO_W];
    assign o_quo   = r_quo[QUO_W];
    assign o_tag   = r_tag[QUO_W];

endmodule

/* sv/great_circle_zone_proximity_check_core.sv */
// A segment passes through the per-point CORDIC chain, the 31-stage square root and
// the 24-stage divider before the result is registered at the output.
// Throughput: one segment per cycle; the whole pipeline holds while a result waits.
// Reset clears all valid bits and the zone registers; no clearing pass is needed.
`include "great_circle_zone_proximity_check_core_macros.svh"

module great_circle_zone_proximity_check_core import gczp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // lat_a, lon_a, alt_a_ft, lat_b, lon_b, alt_b_ft, zero fill
    input  logic [135:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // hit, plane_distance, zero fill
    output logic [23:0]  o_m_tdata,
    // degenerate
    output logic         o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [24:0]  i_cfg_data
);

    logic                    w_en;
    logic                    w_in_acc;
    logic signed [LAT_W-1:0] r_zone_lat;
    logic signed [ANG_W-1:0] r_zone_lon;
    logic signed [ALT_W-1:0] r_zone_alt;
    logic [RAD_W-1:0]        r_zone_radius;

    logic                    w_xv;
    logic signed [CRD_W-1:0] w_a [0:2];
    logic signed [CRD_W-1:0] w_b [0:2];
    logic signed [CRD_W-1:0] w_c [0:2];

    logic signed [59:0]      r1_p [0:5];
    logic signed [CRD_W-1:0] r1_c [0:2];
    logic                    r1_v;
    logic signed [60:0]      r2_n [0:2];
    logic signed [CRD_W-1:0] r2_c [0:2];
    logic                    r2_v;
    logic                    r2_deg;
    logic [60:0]             w_abs [0:2];
    logic [60:0]             w_max;
    logic signed [60:0]      r3_n [0:2];
    logic signed [CRD_W-1:0] r3_c [0:2];
    logic [60:0]             r3_m;
    logic                    r3_v;
    logic                    r3_deg;
    logic [63:0]             w_m64;
    logic [7:0]              w_gnz;
    logic [2:0]              w_gmsb [0:7];
    logic signed [60:0]      r4_n [0:2];
    logic signed [CRD_W-1:0] r4_c [0:2];
    logic [60:0]             r4_m;
    logic [7:0]              r4_gnz;
    logic [2:0]              r4_gmsb [0:7];
    logic                    r4_v;
    logic                    r4_deg;
    logic [6:0]              w_blen;
    logic [6:0]              w_shift;
    logic signed [60:0]      r5_n [0:2];
    logic signed [CRD_W-1:0] r5_c [0:2];
    logic [60:0]             r5_m;
    logic [4:0]              r5_s;
    logic                    r5_v;
    logic                    r5_deg;
    logic signed [60:0]      w_vs [0:2];
    logic signed [30:0]      r6_v [0:2];
    logic signed [CRD_W-1:0] r6_c [0:2];
    logic                    r6_vd;
    logic                    r6_deg;
    logic signed [61:0]      w_sqp [0:2];
    logic signed [60:0]      w_dpp [0:2];
    logic [60:0]             r7_sq [0:2];
    logic signed [60:0]      r7_dp [0:2];
    logic                    r7_v;
    logic                    r7_deg;
    logic [SQ_W-1:0]         r8_sq;
    logic signed [62:0]      r8_dot;
    logic                    r8_v;
    logic                    r8_deg;
    logic signed [62:0]      w_dot_neg;
    t_sq_tag                 w_sq_tag;

    logic                    w_rv;
    logic [ROOT_W-1:0]       w_root;
    t_sq_tag                 w_root_tag;
    logic                    w_qv;
    logic [QUO_W-1:0]        w_quo;
    t_res_tag                w_quo_tag;
    logic signed [DIST_W-1:0] w_dist;
    logic                    w_hit;

    logic                     r_out_vld;
    logic                     r_out_hit;
    logic signed [DIST_W-1:0] r_out_dist;
    logic                     r_out_deg;

    assign w_en        = !r_out_vld || i_m_tready;
    assign o_s_tready  = w_en;
    assign w_in_acc    = i_s_tvalid && w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_lat    <= '0;
            r_zone_lon    <= '0;
            r_zone_alt    <= '0;
            r_zone_radius <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ZONE_LAT:    r_zone_lat    <= i_cfg_data[LAT_W-1:0];
                CFG_ZONE_LON:    r_zone_lon    <= i_cfg_data[ANG_W-1:0];
                CFG_ZONE_ALT:    r_zone_alt    <= i_cfg_data[ALT_W-1:0];
                CFG_ZONE_RADIUS: r_zone_radius <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    gczp_xyz u_pt_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_in_acc),
        .i_lat   ($signed(i_s_tdata[23:0])),
        .i_lon   ($signed(i_s_tdata[48:24])),
        .i_alt   ($signed(i_s_tdata[65:49])),
        .o_valid (w_xv),
        .o_x     (w_a[0]),
        .o_y     (w_a[1]),
        .o_z     (w_a[2])
    );

    gczp_xyz u_pt_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_in_acc),
        .i_lat   ($signed(i_s_tdata[89:66])),
        .i_lon   ($signed(i_s_tdata[114:90])),
        .i_alt   ($signed(i_s_tdata[131:115])),
        .o_valid (),
        .o_x     (w_b[0]),
        .o_y     (w_b[1]),
        .o_z     (w_b[2])
    );

    gczp_xyz u_pt_zone (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_in_acc),
        .i_lat   (r_zone_lat),
        .i_lon   (r_zone_lon),
        .i_alt   (r_zone_alt),
        .o_valid (),
        .o_x     (w_c[0]),
        .o_y     (w_c[1]),
        .o_z     (w_c[2])
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_abs[k] = r2_n[k][60] ? 61'(-r2_n[k]) : 61'(r2_n[k]);
        end
        w_max = w_abs[0];
        if (w_abs[1] > w_max) begin
            w_max = w_abs[1];
        end
        if (w_abs[2] > w_max) begin
            w_max = w_abs[2];
        end
    end

    always_comb begin
        w_m64 = 64'(r3_m);
        for (int g = 0; g < 8; g++) begin
            w_gnz[g]  = |w_m64[8*g +: 8];
            w_gmsb[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (w_m64[8*g + b]) begin
                    w_gmsb[g] = 3'(b);
                end
            end
        end
    end

    always_comb begin
        w_blen = '0;
        for (int g = 0; g < 8; g++) begin
            if (r4_gnz[g]) begin
                w_blen = 7'(8 * g) + 7'(r4_gmsb[g]) + 7'd1;
            end
        end
        w_shift = (w_blen > 7'd30) ? (w_blen - 7'd30) : 7'd0;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_vs[k]  = r5_n[k] >>> r5_s;
            w_sqp[k] = r6_v[k] * r6_v[k];
            w_dpp[k] = r6_v[k] * r6_c[k];
        end
    end

    assign w_dot_neg        = -r8_dot;
    assign w_sq_tag.dot_mag = r8_dot[62] ? w_dot_neg[SQ_W-1:0] : r8_dot[SQ_W-1:0];
    assign w_sq_tag.res.neg = r8_dot[62];
    assign w_sq_tag.res.deg = r8_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_vd <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
        end else if (w_en) begin
            r1_v  <= w_xv;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
            r5_v  <= r4_v;
            r6_vd <= r5_v;
            r7_v  <= r6_vd;
            r8_v  <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_p[0] <= w_a[1] * w_b[2];
            r1_p[1] <= w_a[2] * w_b[1];
            r1_p[2] <= w_a[2] * w_b[0];
            r1_p[3] <= w_a[0] * w_b[2];
            r1_p[4] <= w_a[0] * w_b[1];
            r1_p[5] <= w_a[1] * w_b[0];
            r2_n[0] <= 61'(r1_p[0]) - 61'(r1_p[1]);
            r2_n[1] <= 61'(r1_p[2]) - 61'(r1_p[3]);
            r2_n[2] <= 61'(r1_p[4]) - 61'(r1_p[5]);
            r2_deg  <= (r1_p[0] == r1_p[1]) && (r1_p[2] == r1_p[3])
                    && (r1_p[4] == r1_p[5]);
            r3_m    <= w_max;
            r3_deg  <= r2_deg;
            r4_m    <= r3_m;
            r4_gnz  <= w_gnz;
            r4_deg  <= r3_deg;
            r5_m    <= r4_m;
            r5_s    <= w_shift[4:0];
            r5_deg  <= r4_deg;
            r6_deg  <= r5_deg;
            r7_deg  <= r6_deg;
            r8_sq   <= SQ_W'(r7_sq[0]) + SQ_W'(r7_sq[1]) + SQ_W'(r7_sq[2]);
            r8_dot  <= 63'(r7_dp[0]) + 63'(r7_dp[1]) + 63'(r7_dp[2]);
            r8_deg  <= r7_deg;
            for (int g = 0; g < 8; g++) begin
                r4_gmsb[g] <= w_gmsb[g];
            end
            for (int k = 0; k < 3; k++) begin
                r1_c[k]  <= w_c[k];
                r2_c[k]  <= r1_c[k];
                r3_n[k]  <= r2_n[k];
                r3_c[k]  <= r2_c[k];
                r4_n[k]  <= r3_n[k];
                r4_c[k]  <= r3_c[k];
                r5_n[k]  <= r4_n[k];
                r5_c[k]  <= r4_c[k];
                r6_v[k]  <= w_vs[k][30:0];
                r6_c[k]  <= r5_c[k];
                r7_sq[k] <= w_sqp[k][60:0];
                r7_dp[k] <= w_dpp[k];
            end
        end
    end

    gczp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r8_v),
        .i_sq    (r8_sq),
        .i_tag   (w_sq_tag),
        .o_valid (w_rv),
        .o_root  (w_root),
        .o_tag   (w_root_tag)
    );

    gczp_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_rv),
        .i_root    (w_root),
        .i_dot_mag (w_root_tag.dot_mag),
        .i_tag     (w_root_tag.res),
        .o_valid   (w_qv),
        .o_quo     (w_quo),
        .o_tag     (w_quo_tag)
    );

    always_comb begin
        if (w_quo_tag.deg) begin
            w_dist = '0;
        end else if (!w_quo_tag.neg) begin
            w_dist = (w_quo > DIST_POS_MAX) ? DIST_MAX : $signed(w_quo[DIST_W-1:0]);
        end else if (w_quo > DIST_NEG_MAX) begin
            w_dist = DIST_MIN;
        end else begin
            w_dist = DIST_W'(-$signed({1'b0, w_quo}));
        end
        w_hit = w_quo_tag.deg || (w_quo <= QUO_W'(r_zone_radius));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_qv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_hit  <= w_hit;
            r_out_dist <= w_dist;
            r_out_deg  <= w_quo_tag.deg;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {1'b0, r_out_dist, r_out_hit};
    assign o_m_tuser  = r_out_deg;

    `GCZP_ASSERT_IMPL(a_deg_hit, o_m_tvalid && o_m_tuser, o_m_tdata[0] && (o_m_tdata[22:1] == '0), "degenerate result without hit or with nonzero distance")
    `GCZP_ASSERT_IMPL(a_stall_blocks_input, o_m_tvalid && !i_m_tready, !o_s_tready, "input taken while result is held")
    `GCZP_ASSERT_IMPL(a_norm_shift, r5_v, (r5_m >> r5_s) < LIM_30, "cross product scaling leaves a component at or above 2^30")
    `GCZP_ASSERT_NEXT(a_stall_holds_dot, !w_en, $stable(r8_dot) && $stable(r8_v), "pipeline stage moved during a stall")

endmodule

/* test/zone_check_monitor.sv */
module zone_check_monitor import gczp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [135:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [23:0]  i_m_tdata,
    input  logic         i_m_tuser,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [24:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_DEG     = 65536;
    localparam longint QUARTER_DEG = 90 * ONE_DEG;
    localparam longint HALF_DEG    = 180 * ONE_DEG;
    localparam longint FULL_DEG    = 360 * ONE_DEG;
    localparam longint RAD_SCALE   = 64'sd19190098068;
    localparam longint GAIN        = 652032874;
    localparam longint R_EARTH     = 6371 * 65536;
    localparam longint FT_SCALE    = 1309106;
    localparam longint SAT_HI      = 2097151;
    localparam longint SAT_LO      = -2097152;

    typedef struct packed {
        logic             hit;
        logic [DIST_W-1:0] pdist;
        logic             degen;
    } t_zone_result;

    logic [LAT_W-1:0] center_lat;
    logic [ANG_W-1:0] center_lon;
    logic [ALT_W-1:0] center_alt;
    logic [RAD_W-1:0] center_radius;
    t_zone_result     expected_results[$];
    int               fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    function automatic void cordic_trig(input longint deg, output longint sn, output longint cs);
        longint ang, x, y, z, dx, dy;
        bit     flip;
        ang  = ((deg % FULL_DEG) + FULL_DEG) % FULL_DEG;
        flip = 1'b0;
        x    = GAIN;
        y    = 0;
        if (ang >= HALF_DEG) ang -= FULL_DEG;
        if (ang > QUARTER_DEG) begin
            ang -= HALF_DEG;
            flip = 1'b1;
        end else if (ang < -QUARTER_DEG) begin
            ang += HALF_DEG;
            flip = 1'b1;
        end
        z = (ang * RAD_SCALE) >>> 26;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_Q30[i]);
            end else begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_Q30[i]);
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    function automatic void earth_point(input longint lat, input longint lon, input longint alt,
                                        output longint px, output longint py, output longint pz);
        longint sl, cl, so, co, rad, rc;
        rad = R_EARTH + ((alt * FT_SCALE) >>> 16);
        cordic_trig(lat, sl, cl);
        cordic_trig(lon, so, co);
        rc = (rad * cl) >>> 30;
        px = (rc * co) >>> 30;
        py = (rc * so) >>> 30;
        pz = (rad * sl) >>> 30;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v  -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_zone_result plane_distance_of(input logic [135:0] seg);
        longint          a[3], b[3], c[3], n[3];
        longint          big, dot, dist_val, v;
        longint unsigned sq, norm, q;
        int              sh;
        t_zone_result    r;
        earth_point($signed(seg[23:0]), $signed(seg[48:24]), $signed(seg[65:49]),
                    a[0], a[1], a[2]);
        earth_point($signed(seg[89:66]), $signed(seg[114:90]), $signed(seg[131:115]),
                    b[0], b[1], b[2]);
        earth_point($signed(center_lat), $signed(center_lon), $signed(center_alt),
                    c[0], c[1], c[2]);
        n[0] = a[1] * b[2] - a[2] * b[1];
        n[1] = a[2] * b[0] - a[0] * b[2];
        n[2] = a[0] * b[1] - a[1] * b[0];
        if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
            r.hit   = 1'b1;
            r.pdist = '0;
            r.degen = 1'b1;
            return r;
        end
        big = 0;
        for (int k = 0; k < 3; k++) begin
            v = n[k] < 0 ? -n[k] : n[k];
            if (v > big) big = v;
        end
        sh = 0;
        while ((big >> sh) >= (64'sd1 << 30)) sh++;
        sq  = 0;
        dot = 0;
        for (int k = 0; k < 3; k++) begin
            v    = n[k] >>> sh;
            sq  += longint'(v * v);
            dot += v * c[k];
        end
        norm = root_floor(sq);
        q    = longint'(dot < 0 ? -dot : dot) / (norm * 256);
        dist_val = dot < 0 ? -longint'(q) : longint'(q);
        r.hit = (q <= center_radius);
        if (dist_val > SAT_HI) dist_val = SAT_HI;
        if (dist_val < SAT_LO) dist_val = SAT_LO;
        r.pdist = dist_val[DIST_W-1:0];
        r.degen = 1'b0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_zone_result want, got;
        if (!i_rst_n) begin
            center_lat    <= '0;
            center_lon    <= '0;
            center_alt    <= '0;
            center_radius <= '0;
            fail_count    <= 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ZONE_LAT)    center_lat    <= i_cfg_data[LAT_W-1:0];
                if (i_cfg_index == CFG_ZONE_LON)    center_lon    <= i_cfg_data[ANG_W-1:0];
                if (i_cfg_index == CFG_ZONE_ALT)    center_alt    <= i_cfg_data[ALT_W-1:0];
                if (i_cfg_index == CFG_ZONE_RADIUS) center_radius <= i_cfg_data[RAD_W-1:0];
            end
            if (i_m_tvalid && i_m_tready) begin
                got.hit   = i_m_tdata[0];
                got.pdist = i_m_tdata[DIST_W:1];
                got.degen = i_m_tuser;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result hit=%0b dist=%0d degenerate=%0b",
                             $time, got.hit, $signed(got.pdist), got.degen);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.hit !== got.hit || want.pdist !== got.pdist ||
                        want.degen !== got.degen) begin
                        $display("%0t: mismatch expected hit=%0b dist=%0d degenerate=%0b, %s",
                                 $time, want.hit, $signed(want.pdist), want.degen,
                                 $sformatf("actual hit=%0b dist=%0d degenerate=%0b",
                                           got.hit, $signed(got.pdist), got.degen));
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(plane_distance_of(i_s_tdata));
        end
    end
endmodule

/* test/tb_top.sv */
module tb_top import gczp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LIMIT_CYCLES = 600000;
    localparam int  LAT_SPAN     = 5898240;
    localparam int  LON_SPAN     = 11796480;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [7:0]   cfg_index = '0;
    logic [24:0]  cfg_data = '0;
    int           fail_count, pending;
    int           cycles = 0;
    int           send_idle_pct, recv_stall_pct;

    always #2 i_clk = ~i_clk;

    great_circle_zone_proximity_check_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .o_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    zone_check_monitor checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic logic [135:0] segment(input int lat_a, input int lon_a, input int alt_a,
                                             input int lat_b, input int lon_b, input int alt_b);
        logic [135:0] d;
        d = '0;
        d[23:0]    = lat_a[23:0];
        d[48:24]   = lon_a[24:0];
        d[65:49]   = alt_a[16:0];
        d[89:66]   = lat_b[23:0];
        d[114:90]  = lon_b[24:0];
        d[131:115] = alt_b[16:0];
        return d;
    endfunction

    task automatic send_segment(input logic [135:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[24:0];
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_zone(input int lat, input int lon, input int alt, input int radius);
        write_reg(CFG_ZONE_LAT, lat);
        write_reg(CFG_ZONE_LON, lon);
        write_reg(CFG_ZONE_ALT, alt);
        write_reg(CFG_ZONE_RADIUS, radius);
    endtask

    function automatic int rand_lat();
        return int'($urandom_range(2 * LAT_SPAN)) - LAT_SPAN;
    endfunction

    function automatic int rand_lon();
        return int'($urandom_range(2 * LON_SPAN)) - LON_SPAN;
    endfunction

    function automatic int rand_alt();
        return int'($urandom_range(67583)) - 2048;
    endfunction

    function automatic logic [135:0] random_segment();
        int la, lo, al, sel;
        sel = $urandom_range(99);
        la  = rand_lat();
        lo  = rand_lon();
        al  = rand_alt();
        if (sel < 55)
            return segment(la, lo, al, la + int'($urandom_range(262144)) - 131072,
                           lo + int'($urandom_range(262144)) - 131072, rand_alt());
        else if (sel < 80)
            return segment(la, lo, al, rand_lat(), rand_lon(), rand_alt());
        else if (sel < 85)
            return segment(la, lo, al, la, lo, $urandom_range(1) ? al : rand_alt());
        else
            return {4'b0, 132'({$urandom, $urandom, $urandom, $urandom, $urandom})};
    endfunction

    task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            send_segment(random_segment());
            if (i == count / 2 && idle_pct == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed segments under the reset zone.
        send_segment(segment(0, 0, 0, 0, 0, 0));
        send_segment(segment(LAT_SPAN, LON_SPAN, 65535, -LAT_SPAN, -LON_SPAN, -2048));
        send_segment(segment(0, 0, 0, 0, 90 * 65536, 0));
        send_segment(segment(0, -LON_SPAN, 0, 0, LON_SPAN, 0));
        send_segment(segment(LAT_SPAN, 0, 0, LAT_SPAN, 65536, 0));
        send_segment(segment(-LAT_SPAN, 0, 0, LAT_SPAN, 0, 0));
        send_segment(segment(1000, 2000, 30000, 1000, 2000, 30000));
        send_segment(segment(32'h7fffff, 32'hffffff, 32'hffff, -8388608, -16777216, -65536));
        send_segment(segment(LAT_SPAN + 1, LON_SPAN + 1, 0, -LAT_SPAN - 1, -LON_SPAN - 1, 0));
        send_segment(segment(45 * 65536, 170 * 65536, 100, 45 * 65536, -170 * 65536, 100));
        send_segment(segment(65536, 65536, 0, 65537, 65536, 0));
        wait_drained();
        set_zone(LAT_SPAN, LON_SPAN, 65535, 1048575);
        write_reg(8'd4, 12345);
        write_reg(8'd255, 1);
        send_segment(segment(0, 0, 0, 0, 90 * 65536, 0));
        send_segment(segment(10 * 65536, 20 * 65536, -2048, -30 * 65536, 40 * 65536, 65535));
        send_segment(segment(0, -LON_SPAN, 0, 0, LON_SPAN, 0));
        wait_drained();
        set_zone(-LAT_SPAN, -LON_SPAN, -2048, 0);
        send_segment(segment(0, 0, 0, 0, 90 * 65536, 0));
        send_segment(segment(LAT_SPAN, 0, 0, 0, 0, 0));
        send_segment(segment(-LAT_SPAN, -LON_SPAN, -2048, -LAT_SPAN, LON_SPAN, -2048));
        wait_drained();

        random_phase(350, 0, 0);
        set_zone(rand_lat(), rand_lon(), rand_alt(), $urandom_range(1048575));
        random_phase(350, 52, 0);
        set_zone(rand_lat(), rand_lon(), rand_alt(), $urandom_range(2000));
        random_phase(350, 0, 52);
        set_zone(int'($urandom_range(16777215)) - 8388608, $urandom, $urandom,
                 $urandom_range(1048575));
        random_phase(350, 27, 27);
        set_zone(0, 0, 0, 512);
        random_phase(350, 0, 0);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
